/* rtl/srp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// Shared widths, register codes and state types of the stepper ramp profile.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int SRP_INTERVAL_BITS  = 24;
	localparam int SRP_POSITION_BITS  = 31;
	localparam int SRP_CFG_INDEX_BITS = 1;

	// configuration register indexes
	localparam logic [SRP_CFG_INDEX_BITS-1:0] CFG_FIRST_INTERVAL = 1'd0;
	localparam logic [SRP_CFG_INDEX_BITS-1:0] CFG_MIN_INTERVAL   = 1'd1;

	localparam int SRP_FIRST_RESET = 10000;
	localparam int SRP_MIN_RESET   = 1000;

	// request function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_ABS,
		ST_TICK_STEP,
		ST_TICK_PREP,
		ST_DIV_WAIT,
		ST_TICK_SUM,
		ST_TICK_APPLY,
		ST_EMIT
	} srp_state_t;

	typedef enum logic [1:0] {
		PH_ACCEL,
		PH_DECEL,
		PH_HOLD
	} srp_phase_t;

endpackage
`default_nettype wire

/* rtl/srp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_if
// Request, result and configuration channels of the stepper ramp profile.
// ----------------------------------------------------------------------------
interface srp_in_if import srp_pkg::*; #(
	parameter int POSITION_BITS = SRP_POSITION_BITS
);
	logic                            valid;
	logic                            ready;
	logic                            func;
	logic signed [POSITION_BITS-1:0] target_position;

	modport source (output valid, func, target_position, input ready);
	modport sink (input valid, func, target_position, output ready);
endinterface

interface srp_out_if import srp_pkg::*; #(
	parameter int INTERVAL_BITS = SRP_INTERVAL_BITS,
	parameter int POSITION_BITS = SRP_POSITION_BITS
);
	logic                            valid;
	logic                            ready;
	logic                            step_pulse;
	logic                            dir_level;
	logic [INTERVAL_BITS-1:0]        next_interval_us;
	logic                            move_done;
	logic signed [POSITION_BITS-1:0] position;

	modport source (output valid, step_pulse, dir_level, next_interval_us, move_done,
		position, input ready);
	modport sink (input valid, step_pulse, dir_level, next_interval_us, move_done,
		position, output ready);
endinterface

interface srp_cfg_if import srp_pkg::*; #(
	parameter int INTERVAL_BITS = SRP_INTERVAL_BITS
);
	logic                          valid;
	logic                          ready;
	logic [SRP_CFG_INDEX_BITS-1:0] index;
	logic [INTERVAL_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/stepper_ramp_profile_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_profile_unit
// Trapezoidal stepper speed profile: start requests set up a move, tick
// requests issue steps and update the step interval.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   func, target_position
//  rsp      out  valid/ready   step_pulse, dir_level, next_interval_us,
//                              move_done, position
//  cfg      in   valid/ready   index, data (cfg.ready tied high)
//
//  Start request: ST_START_ABS, ST_EMIT. Tick while done: ST_EMIT. Tick:
//  ST_TICK_STEP, ST_TICK_PREP, ST_DIV_WAIT, ST_TICK_SUM, ST_TICK_APPLY,
//  ST_EMIT, the divider giving one quotient bit per cycle; cruise skips it.
//  One request in flight; cmd.ready is high again once its result sits in the
//  rsp register, so the next request is taken while that result waits.
//  Reset clears all move state; registers take their documented defaults.
// ----------------------------------------------------------------------------
module stepper_ramp_profile_unit import srp_pkg::*; #(
	parameter int INTERVAL_BITS = SRP_INTERVAL_BITS,
	parameter int POSITION_BITS = SRP_POSITION_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	srp_in_if.sink   cmd,
	srp_out_if.source rsp,
	srp_cfg_if.sink  cfg
);

	localparam int IB = INTERVAL_BITS;
	localparam int PB = POSITION_BITS;
	localparam int DW = PB + 2;

	srp_state_t state_q, state_d;

	logic [IB-1:0]        first_q;
	logic [IB-1:0]        min_q;
	logic signed [PB-1:0] pos_q;
	logic [PB-1:0]        total_q;
	logic [PB-1:0]        steps_q;
	logic [PB-1:0]        ramp_q;
	logic [IB-1:0]        ivl_q;
	logic                 neg_q;
	logic                 fin_q;
	logic                 pulse_q;
	logic                 out_valid_q;
	srp_phase_t           phase_q;
	logic                 zero_q;
	logic [PB:0]          diff_q;
	logic [IB:0]          nv_q;

	logic [PB:0]          neg_diff;
	logic [PB:0]          reach_sum;
	logic [PB-1:0]        rem_m1;
	srp_phase_t           phase_c;
	logic                 zero_c;
	logic [DW-1:0]        divisor_c;
	logic                 div_start;
	logic                 div_done;
	logic [IB:0]          div_quo;
	logic [IB:0]          quo_sel;
	logic                 emit_ok;

	// ---- phase decision for a tick (after the step count update)
	assign neg_diff  = -diff_q;
	assign reach_sum = {1'b0, steps_q} + {1'b0, ramp_q};
	assign rem_m1    = total_q + ~steps_q;  // steps remaining minus one

	always_comb begin
		if (ramp_q == '0) begin
			phase_c   = PH_ACCEL;
			zero_c    = steps_q == '0;
			divisor_c = {steps_q, 2'b01};
		end else if (reach_sum >= {1'b0, total_q}) begin
			phase_c   = PH_DECEL;
			zero_c    = total_q == steps_q;
			divisor_c = {rem_m1, 2'b11};
		end else begin
			phase_c   = PH_HOLD;
			zero_c    = 1'b0;
			divisor_c = {rem_m1, 2'b11};
		end
	end

	srp_divider #(
		.DIVIDEND_BITS(IB + 1),
		.DIVISOR_BITS (DW)
	) u_srp_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({ivl_q, 1'b0}),
		.divisor (divisor_c),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign quo_sel = zero_q ? '0 : div_quo;
	assign emit_ok = !out_valid_q || rsp.ready;

	// ---- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if (cmd.func == FUNC_START) begin
						state_d = ST_START_ABS;
					end else if (fin_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_TICK_STEP;
					end
				end
			end
			ST_START_ABS: state_d = ST_EMIT;
			ST_TICK_STEP: state_d = ST_TICK_PREP;
			ST_TICK_PREP: begin
				if (phase_c == PH_HOLD) begin
					state_d = ST_EMIT;
				end else if (zero_c) begin
					state_d = ST_TICK_SUM;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_TICK_SUM;
				end
			end
			ST_TICK_SUM:   state_d = ST_TICK_APPLY;
			ST_TICK_APPLY: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;

	// ---- move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= IB'(SRP_FIRST_RESET);
			min_q       <= IB'(SRP_MIN_RESET);
			pos_q       <= '0;
			total_q     <= '0;
			steps_q     <= '0;
			ramp_q      <= '0;
			ivl_q       <= '0;
			neg_q       <= 1'b0;
			fin_q       <= 1'b1;
			pulse_q     <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_HOLD;
			zero_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_FIRST_INTERVAL) begin
					first_q <= cfg.data;
				end
				if (cfg.index == CFG_MIN_INTERVAL) begin
					min_q <= cfg.data;
				end
			end
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						pulse_q <= 1'b0;
					end
				end
				ST_START_ABS: begin
					total_q <= diff_q[PB] ? neg_diff[PB-1:0] : diff_q[PB-1:0];
					neg_q   <= diff_q[PB];
					steps_q <= '0;
					ramp_q  <= '0;
					ivl_q   <= first_q;
					fin_q   <= 1'b0;
				end
				ST_TICK_STEP: begin
					if (steps_q < total_q) begin
						pulse_q <= 1'b1;
						pos_q   <= neg_q ? pos_q - 1'b1 : pos_q + 1'b1;
						steps_q <= steps_q + 1'b1;
					end else begin
						fin_q <= 1'b1;
					end
				end
				ST_TICK_PREP: begin
					phase_q <= phase_c;
					zero_q  <= zero_c;
				end
				ST_TICK_APPLY: begin
					if (phase_q == PH_ACCEL) begin
						// ramp ends at the cruise interval or at mid-move
						ivl_q <= (nv_q <= {1'b0, min_q}) ? min_q : nv_q[IB-1:0];
						if (nv_q <= {1'b0, min_q} || steps_q >= (total_q >> 1)) begin
							ramp_q <= steps_q;
						end
					end else begin
						ivl_q <= nv_q[IB] ? '1 : nv_q[IB-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			diff_q <= {cmd.target_position[PB-1], cmd.target_position} - {pos_q[PB-1], pos_q};
		end
		if (state_q == ST_TICK_SUM) begin
			// decel: d(4m+1)/(4m-1) == d + 2d/(4m-1)
			nv_q <= (phase_q == PH_ACCEL) ? {1'b0, ivl_q} - quo_sel : {1'b0, ivl_q} + quo_sel;
		end
	end

	// ---- result register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_ok) begin
			rsp.step_pulse       <= pulse_q;
			rsp.dir_level        <= neg_q;
			rsp.next_interval_us <= ivl_q;
			rsp.move_done        <= fin_q;
			rsp.position         <= pos_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/srp_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module srp_divider #(
	parameter int DIVIDEND_BITS = 25,
	parameter int DIVISOR_BITS  = 33
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	localparam int CNT_W = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;
	localparam int CW    = (DIVIDEND_BITS + 1 > DIVISOR_BITS) ? DIVIDEND_BITS + 1
		: DIVISOR_BITS;

	logic [DIVIDEND_BITS-1:0] rem_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  den_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [DIVIDEND_BITS:0]   trial;
	logic [CW-1:0]            trial_w;
	logic [CW-1:0]            diff_w;
	logic                     ge;

	// partial remainder shifted left with the next dividend bit
	assign trial   = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign trial_w = CW'(trial);
	assign ge      = trial_w >= CW'(den_q);
	assign diff_w  = trial_w - CW'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff_w[DIVIDEND_BITS-1:0] : trial[DIVIDEND_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/srp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks of the stepper ramp profile unit.
// ----------------------------------------------------------------------------
module srp_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_step_pulse,
	input logic rsp_move_done
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_pulse_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_step_pulse |-> !rsp_move_done)
		else $error("step pulse reported on a finished move");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second request taken while one is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("result appeared without a request in work");

endmodule

bind stepper_ramp_profile_unit srp_checker u_srp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_step_pulse(rsp.step_pulse),
	.rsp_move_done (rsp.move_done)
);
`default_nettype wire
